[hdl/assert_macros.svh]
// assert_macros.svh: concurrent assertion shorthands for the knps RTL.
// No dependencies; taken in by `include where a module asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define KNPS_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define KNPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KNPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/knps_pkg.sv]
// knps_pkg: widths, beat types and defaults shared by the k-nearest point select.
// No dependencies.
`default_nettype none

package knps_pkg;

   localparam int NEAREST_COUNT_DEFAULT = 4;
   localparam int COORD_W  = 16;
   localparam int SQUARE_W = 2 * COORD_W;
   localparam int DIST_W   = 34;
   localparam int RANK_W   = 2;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIST_W-1:0]  dist_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type center_x;
      coord_type center_y;
      logic      set_end;
   } req_beat_type;

   typedef struct packed {
      coord_type         near_x;
      coord_type         near_y;
      logic [RANK_W-1:0] rank;
      logic              run_last;
   } rsp_beat_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // candidate leaving the distance pipe
   typedef struct packed {
      point_type pt;
      dist_type  sq_dist;
      logic      set_end;
   } cand_type;

endpackage

`default_nettype wire

[hdl/knps_stream_if.sv]
// knps_stream_if: valid/ready channel carrying one beat of a given payload type.
// No dependencies; the payload type is bound where the channel is declared.
`default_nettype none

interface knps_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/knps_distance.sv]
// knps_distance: input register, abs difference and squares, then squared distance.
// Depends on knps_pkg.
`default_nettype none

module knps_distance (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  knps_pkg::req_beat_type in_beat,
   output logic                  out_valid,
   output knps_pkg::cand_type    out_cand
);
   import knps_pkg::*;

   logic         a_valid_ff, a_valid_in;
   req_beat_type a_beat_ff;

   logic                b_valid_ff, b_valid_in;
   point_type           b_pt_ff;
   logic                b_end_ff;
   logic [SQUARE_W-1:0] b_sqx_ff, b_sqy_ff, b_sqx_in, b_sqy_in;

   logic      c_valid_ff, c_valid_in;
   cand_type  c_cand_ff, c_cand_in;

   coord_type         dx, dy;
   logic [SQUARE_W:0] sum;

   always_comb begin
      dx = (a_beat_ff.point_x >= a_beat_ff.center_x) ? a_beat_ff.point_x - a_beat_ff.center_x
                                                      : a_beat_ff.center_x - a_beat_ff.point_x;
      dy = (a_beat_ff.point_y >= a_beat_ff.center_y) ? a_beat_ff.point_y - a_beat_ff.center_y
                                                      : a_beat_ff.center_y - a_beat_ff.point_y;
      b_sqx_in = SQUARE_W'(dx) * SQUARE_W'(dx);
      b_sqy_in = SQUARE_W'(dy) * SQUARE_W'(dy);

      sum = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
      c_cand_in.pt      = b_pt_ff;
      c_cand_in.sq_dist = DIST_W'(sum);
      c_cand_in.set_end = b_end_ff;

      a_valid_in = in_valid;
      b_valid_in = a_valid_ff;
      c_valid_in = b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_beat_ff  <= in_beat;
         b_pt_ff.x  <= a_beat_ff.point_x;
         b_pt_ff.y  <= a_beat_ff.point_y;
         b_end_ff   <= a_beat_ff.set_end;
         b_sqx_ff   <= b_sqx_in;
         b_sqy_ff   <= b_sqy_in;
         c_cand_ff  <= c_cand_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_cand  = c_cand_ff;

endmodule

`default_nettype wire

[hdl/knps_insert.sv]
// knps_insert: sorted list of the nearest points, parallel compare and insert.
// Depends on knps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module knps_insert #(
   parameter int NEAREST_COUNT = knps_pkg::NEAREST_COUNT_DEFAULT,
   localparam int CNT_W = $clog2(NEAREST_COUNT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 commit,
   input  knps_pkg::cand_type   cand,
   output logic                 load,
   output logic [CNT_W-1:0]     load_n,
   output knps_pkg::point_type  load_pts [NEAREST_COUNT]
);
   import knps_pkg::*;

   localparam int K = NEAREST_COUNT;

   point_type        pts_ff  [K];
   point_type        pts_in  [K];
   dist_type         dist_ff [K];
   dist_type         dist_in [K];
   logic [CNT_W-1:0] count_ff, count_in, count_inc;

   logic [K-1:0] le;       // kept entry is no farther than the candidate
   logic [K-1:0] prev_le;

   always_comb begin
      for (int i = 0; i < K; i++) begin
         le[i] = (CNT_W'(i) < count_ff) && (dist_ff[i] <= cand.sq_dist);
      end
      prev_le = K'({le, 1'b1});

      // le is a thermometer: keep the head, drop the candidate at the first
      // farther slot, shift the tail down by one
      pts_in[0]  = le[0] ? pts_ff[0]  : cand.pt;
      dist_in[0] = le[0] ? dist_ff[0] : cand.sq_dist;
      for (int i = 1; i < K; i++) begin
         if (le[i]) begin
            pts_in[i]  = pts_ff[i];
            dist_in[i] = dist_ff[i];
         end else if (prev_le[i]) begin
            pts_in[i]  = cand.pt;
            dist_in[i] = cand.sq_dist;
         end else begin
            pts_in[i]  = pts_ff[i-1];
            dist_in[i] = dist_ff[i-1];
         end
      end

      // a full list either drops the candidate or its last entry
      count_inc = (count_ff != CNT_W'(K)) ? count_ff + CNT_W'(1) : count_ff;
      count_in  = count_ff;
      if (commit) begin
         count_in = cand.set_end ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         pts_ff  <= pts_in;
         dist_ff <= dist_in;
      end
   end

   assign load     = commit && cand.set_end;
   assign load_n   = count_inc;
   assign load_pts = pts_in;

   `KNPS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(K), "kept count above K")
   `KNPS_ASSERT_NEXT(a_flush_clears, clock, reset, load, count_ff == '0, "list kept after set end")
   `KNPS_ASSERT_IMPLY(a_load_nonempty, clock, reset, load, load_n != '0, "set end with empty run")

endmodule

`default_nettype wire

[hdl/knps_drain.sv]
// knps_drain: holds a finished run and sends it nearest first, one beat per cycle while rsp_chan is ready.
// Depends on knps_pkg, knps_stream_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module knps_drain #(
   parameter int NEAREST_COUNT = knps_pkg::NEAREST_COUNT_DEFAULT,
   localparam int CNT_W = $clog2(NEAREST_COUNT + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [CNT_W-1:0]     load_n,
   input  knps_pkg::point_type  load_pts [NEAREST_COUNT],
   output logic                 busy,
   knps_stream_if.source        rsp_chan
);
   import knps_pkg::*;

   localparam int K     = NEAREST_COUNT;
   localparam int IDX_W = (K > 1) ? $clog2(K) : 1;

   point_type        hold_ff [K];
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             fire, last;
   rsp_beat_type     beat;

   always_comb begin
      last = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;
      fire = rsp_chan.valid && rsp_chan.ready;

      n_in   = n_ff;
      idx_in = idx_ff;
      if (load) begin
         n_in   = load_n;
         idx_in = '0;
      end else if (fire) begin
         if (last) begin
            n_in   = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      beat.near_x   = hold_ff[idx_ff].x;
      beat.near_y   = hold_ff[idx_ff].y;
      beat.rank     = RANK_W'(idx_ff);
      beat.run_last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         idx_ff <= '0;
      end else begin
         n_ff   <= n_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= load_pts;
      end
   end

   assign busy             = n_ff != '0;
   assign rsp_chan.valid   = busy;
   assign rsp_chan.payload = beat;

   `KNPS_ASSERT_IMPLY(a_load_idle, clock, reset, load, n_ff == '0, "run loaded over a busy buffer")
   `KNPS_ASSERT_NEXT(a_last_empties, clock, reset, fire && last, n_ff == '0, "buffer busy after last beat")
   `KNPS_ASSERT_IMPLY(a_idx_range, clock, reset, busy, CNT_W'(idx_ff) < n_ff, "read index past run")
   `KNPS_ASSERT_IMPLY(a_load_bound, clock, reset, load, load_n <= CNT_W'(K), "run longer than K")

endmodule

`default_nettype wire

[hdl/k_nearest_point_select.sv]
// k_nearest_point_select: top level, distance pipe, sorted list and output buffer.
// Depends on knps_pkg, knps_stream_if, knps_distance, knps_insert, knps_drain.
`default_nettype none

// Takes one point per cycle on req_chan and keeps the NEAREST_COUNT points
// nearest to the center (squared distance, ties in arrival order). A point
// passes the input, square and sum registers into the sorted list, waiting
// while the pipe is held. On a point marking set end, the list including it
// is moved into an output buffer and sent on rsp_chan nearest first, one beat
// per cycle while rsp_chan is ready, run_last on the final beat; the list
// restarts empty for the next set. Input is taken every cycle; the only stall
// is a set end reaching the list while the buffer sends the previous run,
// holding req_chan.ready low until it is out (at most NEAREST_COUNT beats).
module k_nearest_point_select #(
   parameter int NEAREST_COUNT = knps_pkg::NEAREST_COUNT_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   knps_stream_if.sink   req_chan,
   knps_stream_if.source rsp_chan
);
   import knps_pkg::*;

   localparam int CNT_W = $clog2(NEAREST_COUNT + 1);

   logic             advance;
   logic             cand_valid;
   cand_type         cand;
   logic             commit;
   logic             load;
   logic [CNT_W-1:0] load_n;
   point_type        load_pts [NEAREST_COUNT];
   logic             drain_busy;

   assign advance        = !(cand_valid && cand.set_end && drain_busy);
   assign commit         = cand_valid && advance;
   assign req_chan.ready = advance;

   knps_distance u_distance (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_beat   (req_chan.payload),
      .out_valid (cand_valid),
      .out_cand  (cand)
   );

   knps_insert #(
      .NEAREST_COUNT (NEAREST_COUNT)
   ) u_insert (
      .clock    (clock),
      .reset    (reset),
      .commit   (commit),
      .cand     (cand),
      .load     (load),
      .load_n   (load_n),
      .load_pts (load_pts)
   );

   knps_drain #(
      .NEAREST_COUNT (NEAREST_COUNT)
   ) u_drain (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .load_n   (load_n),
      .load_pts (load_pts),
      .busy     (drain_busy),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
